>>> rtl/swmv_pkg.sv
// ----------------------------------------------------------------------------
// swmv_pkg
// Shared widths, register indexes, types and the vote pick function for the
// sliding window majority filter.
// ----------------------------------------------------------------------------
package swmv_pkg;

    localparam int LBL_W    = 4;   // label field width
    localparam int CNT_W    = 7;   // per-label occurrence count
    localparam int FILL_W   = 7;   // fill count and window length
    localparam int CFG_W    = 7;   // widest configuration register
    localparam int NUM_W    = 5;   // num_labels register
    localparam int CFG_AW   = 1;   // configuration index width
    localparam int GRP      = 4;   // counters per first-level vote group
    localparam int LBL_SPAN = 16;  // labels a 4-bit field can name

    localparam logic [CFG_AW-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_AW-1:0] REG_NUM_LABELS    = 1'b1;

    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 7'd30;
    localparam logic [NUM_W-1:0] NUM_LABELS_RST    = 5'd10;

    // vote candidate: label index and its count, vld marks it eligible
    typedef struct packed {
        logic             vld;
        logic [LBL_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
    } cand_t;

    // count update request from the update stage to the counter bank
    typedef struct packed {
        logic             clear;
        logic             inc_en;
        logic [LBL_W-1:0] inc_idx;
        logic             dec_en;
        logic [LBL_W-1:0] dec_idx;
    } cnt_cmd_t;

    // lo holds the lower label indexes, so it keeps ties
    function automatic cand_t pick(cand_t lo, cand_t hi);
        cand_t res;
        res = lo;
        if (hi.vld && (!lo.vld || (hi.cnt > lo.cnt)))
        begin
            res = hi;
        end
        return res;
    endfunction

endpackage

>>> rtl/swmv_ring.sv
// ----------------------------------------------------------------------------
// swmv_ring
// Label history RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swmv_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [swmv_pkg::LBL_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [swmv_pkg::LBL_W-1:0] wr_data
);

    logic [swmv_pkg::LBL_W-1:0] ring_mem [DEPTH];
    logic [swmv_pkg::LBL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/swmv_count_bank.sv
// ----------------------------------------------------------------------------
// swmv_count_bank
// Row of per-label counters with the first level of the vote tree.
// Each counter watches the increment and decrement indexes itself.
// ----------------------------------------------------------------------------
module swmv_count_bank #(
    parameter int DEPTH = 16,
    parameter int NGRP  = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       commit,
    input  swmv_pkg::cnt_cmd_t         cmd,
    input  logic [swmv_pkg::NUM_W-1:0] n_lbl,
    output swmv_pkg::cand_t            grp_best [NGRP]
);

    logic [swmv_pkg::CNT_W-1:0] cnt_reg  [DEPTH];
    logic [swmv_pkg::CNT_W-1:0] cnt_next [DEPTH];

    always_comb
    begin
        logic [swmv_pkg::CNT_W:0] up;
        for (int i = 0; i < DEPTH; i++)
        begin
            up = {1'b0, cnt_reg[i]};
            if (cmd.inc_en && (cmd.inc_idx == swmv_pkg::LBL_W'(i)))
            begin
                up = up + 1'b1;
            end
            // evicted label drops after the new one is counted
            if (cmd.dec_en && (cmd.dec_idx == swmv_pkg::LBL_W'(i)) && (up != '0))
            begin
                up = up - 1'b1;
            end
            if (cmd.clear)
            begin
                cnt_next[i] = '0;
            end
            else
            begin
                cnt_next[i] = up[swmv_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // best of each group, taken from the updated counts
    always_comb
    begin
        swmv_pkg::cand_t best;
        swmv_pkg::cand_t c;
        for (int g = 0; g < NGRP; g++)
        begin
            best = '0;
            for (int k = 0; k < swmv_pkg::GRP; k++)
            begin
                c = '0;
                if ((g * swmv_pkg::GRP + k) < DEPTH)
                begin
                    c.vld = swmv_pkg::NUM_W'(g * swmv_pkg::GRP + k) < n_lbl;
                    c.idx = swmv_pkg::LBL_W'(g * swmv_pkg::GRP + k);
                    c.cnt = cnt_next[g * swmv_pkg::GRP + k];
                end
                best = swmv_pkg::pick(best, c);
            end
            grp_best[g] = best;
        end
    end

endmodule

>>> rtl/sliding_window_majority_vote_top.sv
// ----------------------------------------------------------------------------
// sliding_window_majority_vote_top
// Majority vote over the most recent labels of a classifier stream.
//
//   port group   dir  contents
//   s_axis       in   tuser[0] mode (1 = clear), tdata[3:0] label
//   m_axis       out  tdata: majority, evicted valid/label, fill, rejected
//   cfg          in   cfg_addr 0 window_length, 1 num_labels
//
// A request passes the update stage, the vote stage register and the
// output register. The ring RAM is read at acceptance and the counter row
// is updated when the update stage commits; ready stays low until then.
// Reset clears pointers, fill and counts at once; no clearing pass is run.
// A stalled result is held in the output register while the next request
// moves through update and the first vote level.
// ----------------------------------------------------------------------------
module sliding_window_majority_vote_top #(
    parameter int WINDOW_MAX = 64,
    parameter int LABEL_MAX  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [swmv_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [swmv_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [3:0] label
    input  logic [0:0]                  s_axis_tuser,  // [0] mode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [3:0] majority_label, [4] evicted_valid, [8:5] evicted_label,
    // [15:9] fill_count, [16] rejected
    output logic [23:0]                 m_axis_tdata
);

    localparam int PTR_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_DEPTH = (LABEL_MAX < swmv_pkg::LBL_SPAN) ? LABEL_MAX
                                                                 : swmv_pkg::LBL_SPAN;
    localparam int NGRP      = (CNT_DEPTH + swmv_pkg::GRP - 1) / swmv_pkg::GRP;
    localparam int FILL_TOP  = (1 << swmv_pkg::FILL_W) - 1;
    localparam int WMAX_FILL = (WINDOW_MAX > FILL_TOP) ? FILL_TOP : WINDOW_MAX;
    localparam int NUM_TOP   = (1 << swmv_pkg::NUM_W) - 1;
    localparam int LMAX_NUM  = (LABEL_MAX > NUM_TOP) ? NUM_TOP : LABEL_MAX;
    localparam int SUM_W     = ((PTR_W > swmv_pkg::FILL_W) ? PTR_W : swmv_pkg::FILL_W) + 1;

    // configuration
    logic [swmv_pkg::CFG_W-1:0]  win_reg;
    logic [swmv_pkg::NUM_W-1:0]  num_reg;
    logic [swmv_pkg::FILL_W-1:0] win_eff;
    logic [swmv_pkg::NUM_W-1:0]  n_eff;

    // window state
    logic [PTR_W-1:0]            oldest_reg;
    logic [PTR_W-1:0]            oldest_next;
    logic [swmv_pkg::FILL_W-1:0] fill_reg;
    logic [swmv_pkg::FILL_W-1:0] fill_next;

    // update stage
    logic                        u_valid_reg;
    logic                        u_mode_reg;
    logic [swmv_pkg::LBL_W-1:0]  u_label_reg;
    logic                        rej;
    logic                        push;
    logic                        evict;
    logic [swmv_pkg::LBL_W-1:0]  ev_label;
    logic [swmv_pkg::LBL_W-1:0]  rd_data;
    logic [SUM_W-1:0]            slot_sum;
    logic [PTR_W-1:0]            slot;
    swmv_pkg::cnt_cmd_t          cnt_cmd;
    swmv_pkg::cand_t             grp_best [NGRP];

    // vote stage
    logic                        a_valid_reg;
    swmv_pkg::cand_t             a_grp_reg [NGRP];
    logic                        a_ev_valid_reg;
    logic [swmv_pkg::LBL_W-1:0]  a_ev_label_reg;
    logic [swmv_pkg::FILL_W-1:0] a_fill_reg;
    logic                        a_rej_reg;
    swmv_pkg::cand_t             final_best;

    // output register
    logic                        o_valid_reg;
    logic [swmv_pkg::LBL_W-1:0]  o_maj_reg;
    logic                        o_ev_valid_reg;
    logic [swmv_pkg::LBL_W-1:0]  o_ev_label_reg;
    logic [swmv_pkg::FILL_W-1:0] o_fill_reg;
    logic                        o_rej_reg;

    logic in_accept;
    logic out_load;
    logic a_free;
    logic s1_commit;

    assign out_load      = a_valid_reg && (!o_valid_reg || m_axis_tready);
    assign a_free        = !a_valid_reg || out_load;
    assign s1_commit     = u_valid_reg && a_free;
    // interlock: the next ring read waits until pointer and ring write retire
    assign s_axis_tready = !u_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= swmv_pkg::WINDOW_LENGTH_RST;
            num_reg <= swmv_pkg::NUM_LABELS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                swmv_pkg::REG_WINDOW_LENGTH: win_reg <= cfg_wdata;
                swmv_pkg::REG_NUM_LABELS:    num_reg <= cfg_wdata[swmv_pkg::NUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (win_reg == '0)
        begin
            win_eff = swmv_pkg::FILL_W'(1);
        end
        else if (int'(win_reg) > WINDOW_MAX)
        begin
            win_eff = swmv_pkg::FILL_W'(WMAX_FILL);
        end
        else
        begin
            win_eff = win_reg;
        end
        if (int'(num_reg) > LABEL_MAX)
        begin
            n_eff = swmv_pkg::NUM_W'(LMAX_NUM);
        end
        else
        begin
            n_eff = num_reg;
        end
    end

    swmv_ring #(
        .DEPTH (WINDOW_MAX),
        .AW    (PTR_W)
    ) u_ring (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (oldest_reg),
        .rd_data (rd_data),
        .wr_en   (s1_commit && push),
        .wr_addr (slot),
        .wr_data (u_label_reg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            u_valid_reg <= 1'b1;
        end
        else if (s1_commit)
        begin
            u_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            u_mode_reg  <= s_axis_tuser[0];
            u_label_reg <= s_axis_tdata[swmv_pkg::LBL_W-1:0];
        end
    end

    always_comb
    begin
        rej      = (u_mode_reg == swmv_pkg::MODE_PUSH) && ({1'b0, u_label_reg} >= n_eff);
        push     = (u_mode_reg == swmv_pkg::MODE_PUSH) && !rej;
        evict    = push && (fill_reg >= win_eff);
        ev_label = evict ? rd_data : '0;

        slot_sum = SUM_W'(oldest_reg) + SUM_W'(fill_reg);
        if (slot_sum >= SUM_W'(WINDOW_MAX))
        begin
            slot_sum = slot_sum - SUM_W'(WINDOW_MAX);
        end
        slot = slot_sum[PTR_W-1:0];

        oldest_next = oldest_reg;
        if (evict)
        begin
            oldest_next = (oldest_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : oldest_reg + 1'b1;
        end

        if (u_mode_reg == swmv_pkg::MODE_CLEAR)
        begin
            fill_next = '0;
        end
        else if (push && !evict)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else
        begin
            fill_next = fill_reg;
        end

        cnt_cmd.clear   = (u_mode_reg == swmv_pkg::MODE_CLEAR);
        cnt_cmd.inc_en  = push;
        cnt_cmd.inc_idx = u_label_reg;
        cnt_cmd.dec_en  = evict;
        cnt_cmd.dec_idx = ev_label;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            fill_reg   <= '0;
        end
        else if (s1_commit)
        begin
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
        end
    end

    swmv_count_bank #(
        .DEPTH (CNT_DEPTH),
        .NGRP  (NGRP)
    ) u_count_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (s1_commit),
        .cmd      (cnt_cmd),
        .n_lbl    (n_eff),
        .grp_best (grp_best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s1_commit)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_commit)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                a_grp_reg[g] <= grp_best[g];
            end
            a_ev_valid_reg <= evict;
            a_ev_label_reg <= ev_label;
            a_fill_reg     <= fill_next;
            a_rej_reg      <= rej;
        end
    end

    always_comb
    begin
        final_best = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            final_best = swmv_pkg::pick(final_best, a_grp_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_maj_reg      <= final_best.idx;
            o_ev_valid_reg <= a_ev_valid_reg;
            o_ev_label_reg <= a_ev_label_reg;
            o_fill_reg     <= a_fill_reg;
            o_rej_reg      <= a_rej_reg;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {7'b0, o_rej_reg, o_fill_reg, o_ev_label_reg,
                            o_ev_valid_reg, o_maj_reg};

    // fill never grows past the ring
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= WINDOW_MAX)
        else $error("fill beyond ring depth");

    a_oldest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_commit && !evict |=> $stable(oldest_reg))
        else $error("oldest pointer moved without eviction");

    a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_commit && push && !evict |=>
            fill_reg == swmv_pkg::FILL_W'($past(fill_reg) + 1'b1))
        else $error("push without eviction did not grow fill");

    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_commit && rej |=> $stable(fill_reg) && $stable(oldest_reg))
        else $error("rejected request changed window state");

    a_no_read_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        u_valid_reg && !s1_commit |=> u_valid_reg && $stable(oldest_reg))
        else $error("update stage lost while stalled");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window majority filter. A short table
// of directed requests covers reset values, evictions, window and label
// count extremes, rejections and clears. Random phases follow under several
// register settings and idle patterns, with one long output stall. Results of
// typed rows are checked against the table, the rest against an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int   RING_DEPTH = 64;
    localparam int   CLK_HALF   = 5;

    typedef struct packed {
        logic                        rejected;
        logic [swmv_pkg::FILL_W-1:0] fill;
        logic [swmv_pkg::LBL_W-1:0]  ev_label;
        logic                        ev_valid;
        logic [swmv_pkg::LBL_W-1:0]  majority;
    } vote_res_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        logic [swmv_pkg::CFG_AW-1:0] reg_idx;
        logic [swmv_pkg::CFG_W-1:0]  reg_val;
        logic                        mode;
        logic [swmv_pkg::LBL_W-1:0]  lbl;
        logic                        typed;
        vote_res_t                   res;
    } dir_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [swmv_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [swmv_pkg::CFG_W-1:0]  cfg_wdata = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata = '0;   // [3:0] label
    logic [0:0]                  s_axis_tuser = '0;   // [0] mode
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    // [3:0] majority_label, [4] evicted_valid, [8:5] evicted_label,
    // [15:9] fill_count, [16] rejected
    logic [23:0]                 m_axis_tdata;

    // window model
    logic [swmv_pkg::LBL_W-1:0]  win_labels [RING_DEPTH];
    logic [5:0]                  head_ptr = '0;
    logic [swmv_pkg::FILL_W-1:0] win_fill = '0;
    logic [swmv_pkg::CNT_W-1:0]  lbl_count [swmv_pkg::LBL_SPAN];
    logic [swmv_pkg::CFG_W-1:0]  cfg_window = swmv_pkg::WINDOW_LENGTH_RST;
    logic [swmv_pkg::NUM_W-1:0]  cfg_labels = swmv_pkg::NUM_LABELS_RST;

    vote_res_t         votes_pending [$];
    logic              typed_valid = 1'b0;
    vote_res_t         typed_res = '0;
    int                mismatch_count = 0;
    int                tx_idle_pct = 15;
    int                rx_idle_pct = 70;
    int                stall_orders = 0;
    dir_row_t          dir_rows [$];

    sliding_window_majority_vote_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("sliding_window_majority_vote_top verification failed");
        $finish;
    end

    // advance the window by one request and return the vote after it
    function automatic vote_res_t vote_step(input logic mode,
                                            input logic [swmv_pkg::LBL_W-1:0] lbl);
        vote_res_t        r;
        int               win;
        int               nl;
        int               best;
        int               best_cnt;
        logic [5:0]       slot;
        r = '0;
        win = (cfg_window == 0) ? 1 : ((cfg_window > RING_DEPTH) ? RING_DEPTH : cfg_window);
        nl = (cfg_labels > swmv_pkg::LBL_SPAN) ? swmv_pkg::LBL_SPAN : cfg_labels;
        if (mode == swmv_pkg::MODE_CLEAR)
        begin
            win_fill = '0;
            foreach (lbl_count[i])
                lbl_count[i] = '0;
        end
        else if (lbl >= nl)
        begin
            r.rejected = 1'b1;
        end
        else
        begin
            if (int'(win_fill) + 1 > win)
            begin
                r.ev_valid = 1'b1;
                r.ev_label = win_labels[head_ptr];
            end
            slot = head_ptr + win_fill[5:0];
            win_labels[slot] = lbl;
            lbl_count[lbl] = lbl_count[lbl] + 1'b1;
            win_fill = win_fill + 1'b1;
            if (r.ev_valid)
            begin
                if (lbl_count[r.ev_label] != 0)
                    lbl_count[r.ev_label] = lbl_count[r.ev_label] - 1'b1;
                head_ptr = head_ptr + 1'b1;
                win_fill = win_fill - 1'b1;
            end
        end
        best = 0;
        best_cnt = 0;
        for (int i = 0; i < nl; i++)
        begin
            if (i == 0 || int'(lbl_count[i]) > best_cnt)
            begin
                best = i;
                best_cnt = int'(lbl_count[i]);
            end
        end
        r.majority = best[swmv_pkg::LBL_W-1:0];
        r.fill = win_fill;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
        mismatch_count++;
    endtask

    task automatic check_result(input vote_res_t got, input vote_res_t want);
        if (got.majority !== want.majority)
            report_mismatch("majority_label", int'(got.majority), int'(want.majority));
        if (got.ev_valid !== want.ev_valid)
            report_mismatch("evicted_valid", int'(got.ev_valid), int'(want.ev_valid));
        if (got.ev_label !== want.ev_label)
            report_mismatch("evicted_label", int'(got.ev_label), int'(want.ev_label));
        if (got.fill !== want.fill)
            report_mismatch("fill_count", int'(got.fill), int'(want.fill));
        if (got.rejected !== want.rejected)
            report_mismatch("rejected", int'(got.rejected), int'(want.rejected));
    endtask

    // retire results first: a request taken at this edge cannot be out yet
    always @(posedge clk)
    begin : vote_monitor
        vote_res_t got;
        vote_res_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[16:0];
                if (votes_pending.size() == 0)
                    report_mismatch("unexpected result, majority_label",
                                    int'(got.majority), 0);
                else
                    check_result(got, votes_pending.pop_front());
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = vote_step(s_axis_tuser[0], s_axis_tdata[swmv_pkg::LBL_W-1:0]);
                votes_pending.push_back(typed_valid ? typed_res : want);
            end
        end
    end

    // output side: random stalls, plus a long hold when ordered
    initial
    begin : result_sink
        int hold_left;
        int stalls_seen;
        hold_left = 0;
        stalls_seen = 0;
        forever
        begin
            @(negedge clk);
            if (stall_orders != stalls_seen)
            begin
                stalls_seen = stall_orders;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic mode, input logic [swmv_pkg::LBL_W-1:0] lbl,
                             input logic typed, input vote_res_t res);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = mode;
        s_axis_tdata = {4'b0000, lbl};
        typed_valid = typed;
        typed_res = res;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        @(negedge clk);
    endtask

    task automatic settle_idle();
        s_axis_tvalid = 1'b0;
        typed_valid = 1'b0;
        while (votes_pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [swmv_pkg::CFG_AW-1:0] idx,
                             input logic [swmv_pkg::CFG_W-1:0] val);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        if (idx == swmv_pkg::REG_WINDOW_LENGTH)
            cfg_window = val;
        else
            cfg_labels = val[swmv_pkg::NUM_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic dir_row_t row_cfg(input logic [swmv_pkg::CFG_AW-1:0] idx,
                                         input logic [swmv_pkg::CFG_W-1:0] val);
        dir_row_t r;
        r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, mode: swmv_pkg::MODE_PUSH,
              lbl: '0, typed: 1'b0, res: '0};
        return r;
    endfunction

    function automatic dir_row_t row_item(input logic mode,
                                          input logic [swmv_pkg::LBL_W-1:0] lbl);
        dir_row_t r;
        r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, mode: mode,
              lbl: lbl, typed: 1'b0, res: '0};
        return r;
    endfunction

    function automatic dir_row_t row_typed(input logic mode,
                                           input logic [swmv_pkg::LBL_W-1:0] lbl,
                                           input logic [swmv_pkg::LBL_W-1:0] maj,
                                           input logic evv,
                                           input logic [swmv_pkg::LBL_W-1:0] evl,
                                           input logic [swmv_pkg::FILL_W-1:0] fill,
                                           input logic rej);
        dir_row_t r;
        r = row_item(mode, lbl);
        r.typed = 1'b1;
        r.res.majority = maj;
        r.res.ev_valid = evv;
        r.res.ev_label = evl;
        r.res.fill = fill;
        r.res.rejected = rej;
        return r;
    endfunction

    task automatic run_segment(input logic [swmv_pkg::CFG_W-1:0] win,
                               input logic [swmv_pkg::CFG_W-1:0] nl,
                               input int n_items, input bit hold_out);
        int                         eff_nl;
        logic [swmv_pkg::LBL_W-1:0] fav;
        logic [swmv_pkg::LBL_W-1:0] lbl;
        logic                       mode;
        settle_idle();
        write_reg(swmv_pkg::REG_WINDOW_LENGTH, win);
        write_reg(swmv_pkg::REG_NUM_LABELS, nl);
        // start the long output hold only once requests are about to flow
        if (hold_out)
            stall_orders++;
        eff_nl = (int'(nl) > swmv_pkg::LBL_SPAN) ? swmv_pkg::LBL_SPAN : int'(nl);
        fav = (eff_nl == 0) ? '0 : swmv_pkg::LBL_W'($urandom_range(eff_nl - 1));
        for (int k = 0; k < n_items; k++)
        begin
            mode = ($urandom_range(99) < 3) ? swmv_pkg::MODE_CLEAR : swmv_pkg::MODE_PUSH;
            // bias toward one label so that real majorities form
            if (eff_nl == 0 || $urandom_range(99) < 12)
                lbl = swmv_pkg::LBL_W'($urandom_range(swmv_pkg::LBL_SPAN - 1));
            else if ($urandom_range(1) == 1)
                lbl = fav;
            else
                lbl = swmv_pkg::LBL_W'($urandom_range(eff_nl - 1));
            send_item(mode, lbl, 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        foreach (lbl_count[i])
            lbl_count[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: window 30, ten labels
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd0,  4'd0,  1'b0, 4'd0,
                                     7'd1, 1'b0));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd9,  4'd0,  1'b0, 4'd0,
                                     7'd2, 1'b0));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd10, 4'd0,  1'b0, 4'd0,
                                     7'd2, 1'b1));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd15, 4'd0,  1'b0, 4'd0,
                                     7'd2, 1'b1));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd9,  4'd9,  1'b0, 4'd0,
                                     7'd3, 1'b0));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_CLEAR, 4'd15, 4'd0,  1'b0, 4'd0,
                                     7'd0, 1'b0));
        // two-deep window, all sixteen labels: evictions
        dir_rows.push_back(row_cfg(swmv_pkg::REG_WINDOW_LENGTH, 7'd2));
        dir_rows.push_back(row_cfg(swmv_pkg::REG_NUM_LABELS, 7'd16));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd15, 4'd15, 1'b0, 4'd0,
                                     7'd1, 1'b0));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd15, 4'd15, 1'b0, 4'd0,
                                     7'd2, 1'b0));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd4,  4'd4,  1'b1, 4'd15,
                                     7'd2, 1'b0));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd4,  4'd4,  1'b1, 4'd15,
                                     7'd2, 1'b0));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd0,  4'd0,  1'b1, 4'd4,
                                     7'd2, 1'b0));
        // zero window acts as one; fill above the window holds, one eviction per push
        dir_rows.push_back(row_cfg(swmv_pkg::REG_WINDOW_LENGTH, 7'd0));
        dir_rows.push_back(row_item(swmv_pkg::MODE_PUSH, 4'd7));
        dir_rows.push_back(row_item(swmv_pkg::MODE_PUSH, 4'd7));
        // oversized window, then no valid labels at all
        dir_rows.push_back(row_cfg(swmv_pkg::REG_WINDOW_LENGTH, 7'd127));
        dir_rows.push_back(row_cfg(swmv_pkg::REG_NUM_LABELS, 7'd0));
        dir_rows.push_back(row_typed(swmv_pkg::MODE_PUSH,  4'd0,  4'd0,  1'b0, 4'd0,
                                     7'd2, 1'b1));
        // oversized label count saturates; single label keeps higher counts aside
        dir_rows.push_back(row_cfg(swmv_pkg::REG_NUM_LABELS, 7'd31));
        dir_rows.push_back(row_item(swmv_pkg::MODE_PUSH, 4'd15));
        dir_rows.push_back(row_cfg(swmv_pkg::REG_NUM_LABELS, 7'd1));
        dir_rows.push_back(row_item(swmv_pkg::MODE_PUSH, 4'd0));
        dir_rows.push_back(row_item(swmv_pkg::MODE_PUSH, 4'd1));
        dir_rows.push_back(row_item(swmv_pkg::MODE_CLEAR, 4'd0));
        dir_rows.push_back(row_item(swmv_pkg::MODE_PUSH, 4'd0));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                settle_idle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
            begin
                send_item(dir_rows[i].mode, dir_rows[i].lbl, dir_rows[i].typed,
                          dir_rows[i].res);
            end
        end

        run_segment(7'd64, 7'd16, 110, 1'b0);
        run_segment(7'd3,  7'd16, 110, 1'b0);   // shrink well below the fill
        run_segment(7'd127, 7'd4, 100, 1'b0);

        tx_idle_pct = 70;
        rx_idle_pct = 15;
        run_segment(7'd0,  7'd31, 100, 1'b0);
        run_segment(7'd17, 7'd0,  30, 1'b0);
        run_segment(7'd40, 7'd1,  110, 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // hold the output off for a long stretch while requests keep coming
        run_segment(7'd8,  7'd12, 120, 1'b1);
        run_segment(7'd64, 7'd16, 120, 1'b0);

        settle_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && votes_pending.size() == 0)
            $display("sliding_window_majority_vote_top verification clean");
        else
            $display("sliding_window_majority_vote_top verification failed");
        $finish;
    end

endmodule
